/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Shared widths, lane codes, pipeline payload types and the square root step.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ELEM_W = 16;
	localparam int NUM_ELEM = 9;
	localparam int IN_W = ELEM_W * NUM_ELEM;
	localparam int SUM_W = ELEM_W + 2;
	localparam int MAG_W = SUM_W - 1;
	localparam int ROOT_W = (MAG_W + FRAC_BITS + 1) / 2;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int STEPS_PER_STAGE = 4;
	localparam int SQRT_STAGES = ROOT_W / STEPS_PER_STAGE;
	localparam int NUM_Q = 4;
	localparam int QW_W = 15;
	localparam int QV_W = 16;
	localparam int OUT_BITS = QW_W + 3 * QV_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int ONE = 1 << FRAC_BITS;

	localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE);

	localparam int LANE_W = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;
	localparam int LANE_Z = 3;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0] rem;
	} sqrt_lane_t;

	typedef struct packed {
		sqrt_lane_t [NUM_Q-1:0] lane;
		logic [NUM_Q-1:0] neg;
	} sqrt_data_t;

	function automatic sqrt_lane_t sqrt_step(sqrt_lane_t l);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		sqrt_lane_t o;
		r = {l.rem[REM_W-3:0], l.rad[RAD_W-1 -: 2]};
		t = REM_W'({l.root, 2'b01});
		o.rad = {l.rad[RAD_W-3:0], 2'b00};
		if (r >= t) begin
			o.rem = r - t;
			o.root = {l.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem = r;
			o.root = {l.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

/* rtl/rmq_sum_stage.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion, input stage
// Forms the four diagonal sums, clamps them at zero and records the signs.
// ----------------------------------------------------------------------------
module rmq_sum_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rmq_pkg::IN_W-1:0]  in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rmq_pkg::sqrt_data_t       out_data
);
	import rmq_pkg::*;

	logic signed [SUM_W-1:0] e [NUM_ELEM];
	logic signed [SUM_W-1:0] sum [NUM_Q];
	sqrt_data_t next_d;
	logic v_s1;
	sqrt_data_t d_s1;

	function automatic logic [RAD_W-1:0] to_radicand(logic signed [SUM_W-1:0] s);
		logic [MAG_W-1:0] m;
		if (s[SUM_W-1])
			m = '0;
		else
			m = s[MAG_W-1:0];
		return RAD_W'({m, {FRAC_BITS{1'b0}}});
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++)
			e[i] = SUM_W'($signed(in_data[i*ELEM_W +: ELEM_W]));
		sum[LANE_W] = ONE_S + e[0] + e[4] + e[8];
		sum[LANE_X] = ONE_S + e[0] - e[4] - e[8];
		sum[LANE_Y] = ONE_S - e[0] + e[4] - e[8];
		sum[LANE_Z] = ONE_S - e[0] - e[4] + e[8];
		for (int k = 0; k < NUM_Q; k++) begin
			next_d.lane[k].rad = to_radicand(sum[k]);
			next_d.lane[k].root = '0;
			next_d.lane[k].rem = '0;
		end
		next_d.neg[LANE_W] = 1'b0;
		next_d.neg[LANE_X] = e[7] < e[5];
		next_d.neg[LANE_Y] = e[2] < e[6];
		next_d.neg[LANE_Z] = e[3] < e[1];
	end

	assign in_ready = ~v_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= next_d;
		end
	end

	assign out_valid = v_s1;
	assign out_data = d_s1;

endmodule

/* rtl/rmq_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion, square root stage
// Runs four restoring square root steps on each of the four lanes.
// ----------------------------------------------------------------------------
module rmq_sqrt_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rmq_pkg::sqrt_data_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rmq_pkg::sqrt_data_t  out_data
);
	import rmq_pkg::*;

	sqrt_data_t next_d;
	logic v_q;
	sqrt_data_t d_q;

	always_comb begin
		next_d = in_data;
		for (int k = 0; k < NUM_Q; k++)
			for (int j = 0; j < STEPS_PER_STAGE; j++)
				next_d.lane[k] = sqrt_step(next_d.lane[k]);
	end

	assign in_ready = ~v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= next_d;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;

endmodule

/* rtl/rmq_out_stage.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion, output stage
// Halves and saturates each root, applies the signs and holds the result.
// ----------------------------------------------------------------------------
module rmq_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rmq_pkg::sqrt_data_t        in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rmq_pkg::OUT_W-1:0]  out_data
);
	import rmq_pkg::*;

	logic [QW_W-1:0] mag [NUM_Q];
	logic [QV_W-1:0] sv [NUM_Q];
	logic [OUT_W-1:0] next_d;
	logic v_q;
	logic [OUT_W-1:0] d_q;

	always_comb begin
		for (int k = 0; k < NUM_Q; k++) begin
			mag[k] = in_data.lane[k].root[ROOT_W-1:1];
			if (mag[k] > QW_W'(ONE))
				mag[k] = QW_W'(ONE);
			if (in_data.neg[k])
				sv[k] = QV_W'(0) - QV_W'(mag[k]);
			else
				sv[k] = QV_W'(mag[k]);
		end
		next_d = OUT_W'({sv[LANE_Z], sv[LANE_Y], sv[LANE_X], mag[LANE_W]});
	end

	assign in_ready = ~v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= next_d;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;

endmodule

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Converts a 3x3 rotation matrix in signed Q1.14 to a quaternion in Q1.14.
//
// A matrix arrives as one transfer on the s_axis channel and its quaternion
// leaves as one transfer on the m_axis channel, in the same order.
// The pipeline has six register stages: one for the diagonal sums and signs,
// four for the square roots (four root bits per stage, set by STEPS_PER_STAGE
// in the package), and one output register that halves, saturates and signs.
// One matrix can enter every cycle, so the sustained throughput is one result
// per cycle while the receiver keeps m_axis_tready high.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor can take its contents, so bubbles are squeezed out while the
// receiver stalls, and a stall neither drops nor repeats a transfer.
// Reset clears all valid bits; the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
	input  logic [rmq_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// qw (15 bits), qx (16), qy (16), qz (16), one zero pad bit
	output logic [rmq_pkg::OUT_W-1:0]  m_axis_tdata
);
	import rmq_pkg::*;

	logic       stg_valid [SQRT_STAGES+1];
	logic       stg_ready [SQRT_STAGES+1];
	sqrt_data_t stg_data  [SQRT_STAGES+1];

	rmq_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_data  (stg_data[0])
	);

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		rmq_sqrt_stage u_sqrt (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	rmq_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[SQRT_STAGES]),
		.in_ready  (stg_ready[SQRT_STAGES]),
		.in_data   (stg_data[SQRT_STAGES]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
